/* rtl/stli_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stli_pkg: shared types and codes for the breakpoint table interpolator
// Status codes, command codes and the divider request bundle.
// ----------------------------------------------------------------------------
package stli_pkg;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_LOAD  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  localparam logic [2:0] ST_LOADED  = 3'd0;
  localparam logic [2:0] ST_CLEARED = 3'd1;
  localparam logic [2:0] ST_EXACT   = 3'd2;
  localparam logic [2:0] ST_INTERP  = 3'd3;
  localparam logic [2:0] ST_CLAMPED = 3'd4;
  localparam logic [2:0] ST_EMPTY   = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  // numerator magnitude: 17-bit by 17-bit product
  localparam int NUM_W = 34;
  localparam int DEN_W = 17;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num_mag;
    logic [DEN_W-1:0]  den;
  } div_req_t;

endpackage
`default_nettype wire

/* rtl/sorted_table_linear_interpolator_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_top: breakpoint table with linear lookup
// Loads, sorts and interpolates over a table of signed (x, y) pairs.
// ----------------------------------------------------------------------------
// Issue a beat with start while busy is low; one result beat comes back on
// done, held for one cycle only, and the receiver cannot stall it. Clear,
// load and a query on an empty table answer in the cycle after the accepting
// edge and leave busy low. Command code 3 is taken and dropped with no result.
// A query scans the table entry by entry, a read state then a compare state,
// until it hits, and an interpolated one then registers the product and runs
// the serial divider; the first query after loads first runs a selection sort
// through the single-port table memories. Both scan and sort are set by the
// one table read port.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator_top #(
  parameter int TABLE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic signed [15:0] x_value,
  input  wire logic signed [15:0] y_value,
  output logic             done,
  output logic [2:0]       status,
  output logic signed [15:0] y_result,
  output logic [6:0]       entry_count
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int NW = stli_pkg::NUM_W;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SI    = 4'd1;  // sort: read candidate i
  localparam logic [3:0] S_SJ    = 4'd2;  // sort: compare candidate
  localparam logic [3:0] S_SW0   = 4'd3;  // sort: read entry i
  localparam logic [3:0] S_SW1   = 4'd4;  // sort: write best to i
  localparam logic [3:0] S_SW2   = 4'd5;  // sort: write old i to best
  localparam logic [3:0] S_QR    = 4'd6;  // scan: issue read
  localparam logic [3:0] S_QC    = 4'd7;  // scan: compare
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_DWAIT = 4'd9;
  localparam logic [3:0] S_SWR   = 4'd10;

  logic [3:0]     state;
  logic [CW-1:0]  count;
  logic           is_sorted;
  logic [CW-1:0]  i, j;
  logic [AW-1:0]  best;
  logic signed [15:0] bx, by, px, py, q;
  logic           we;
  logic [AW-1:0]  addr;
  logic [15:0]    wx, wy, rx, ry;
  logic           first;
  logic signed [16:0] dq, dy;
  logic signed [33:0] prod;
  logic           neg;
  stli_pkg::div_req_t dreq;
  logic           ddone;
  logic [NW-1:0]  quot;

  stli_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_ram_x (
    .clk(clk), .we(we), .addr(addr), .wdata(wx), .rdata(rx));
  stli_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_ram_y (
    .clk(clk), .we(we), .addr(addr), .wdata(wy), .rdata(ry));
  stli_div u_div (.clk(clk), .rst(rst), .req(dreq), .done(ddone), .quot(quot));

  assign busy = (state != S_IDLE);
  assign entry_count = 7'(count);

  // memory port steering per state
  always_comb begin
    we   = 1'b0;
    addr = j[AW-1:0];
    wx   = x_value;
    wy   = y_value;
    case (state)
      S_IDLE: begin
        addr = count[AW-1:0];
        we   = start && !busy && command == stli_pkg::CMD_LOAD &&
               count < CW'(TABLE_DEPTH);
      end
      S_SI:   addr = i[AW-1:0];
      S_SW0:  addr = i[AW-1:0];
      S_SW1: begin
        addr = i[AW-1:0]; we = 1'b1; wx = bx; wy = by;
      end
      S_SW2: begin
        addr = best; we = 1'b1; wx = px; wy = py;
      end
      default: addr = j[AW-1:0];
    endcase
  end

  // signed product operands
  always_comb begin
    dq   = 17'(q) - 17'(px);
    dy   = 17'(by) - 17'(py);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      is_sorted <= 1'b1;
      done      <= 1'b0;
      dreq.start <= 1'b0;
    end else begin
      done       <= 1'b0;
      dreq.start <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            q <= x_value;
            y_result <= '0;
            case (command)
              stli_pkg::CMD_CLEAR: begin
                count <= '0; is_sorted <= 1'b1;
                status <= stli_pkg::ST_CLEARED; done <= 1'b1;
              end
              stli_pkg::CMD_LOAD: begin
                if (count < CW'(TABLE_DEPTH)) begin
                  count <= count + 1'b1; is_sorted <= 1'b0;
                  status <= stli_pkg::ST_LOADED;
                end else begin
                  status <= stli_pkg::ST_FULL;
                end
                done <= 1'b1;
              end
              stli_pkg::CMD_QUERY: begin
                if (count == '0) begin
                  status <= stli_pkg::ST_EMPTY; done <= 1'b1;
                end else if (!is_sorted) begin
                  i <= '0; j <= '0; state <= S_SI;
                end else begin
                  j <= '0; first <= 1'b1; state <= S_QR;
                end
              end
              default: ;
            endcase
          end
        end
        // sort: start pass at i, best = i; finish the sort once i reaches count
        S_SI: begin
          if (i == count) begin
            is_sorted <= 1'b1; j <= '0; first <= 1'b1; state <= S_QR;
          end else begin
            j <= i; best <= i[AW-1:0]; first <= 1'b1; state <= S_SJ;
          end
        end
        S_SJ: begin
          // j was addressed last cycle; compare its data
          if (first || $signed(rx) < bx) begin
            bx <= rx; by <= ry; best <= j[AW-1:0];
          end
          first <= 1'b0;
          if (j + 1'b1 == count) begin
            state <= S_SW0;
          end else begin
            j <= j + 1'b1; state <= S_SWR;
          end
        end
        S_SWR: state <= S_SJ;
        S_SW0: state <= S_SW1;
        S_SW1: begin
          px <= rx; py <= ry; state <= S_SW2;
        end
        S_SW2: begin
          i <= i + 1'b1; state <= S_SI;
        end
        // scan: wait for the registered read data
        S_QR: state <= S_QC;
        S_QC: begin
          if ($signed(rx) == q) begin
            status <= stli_pkg::ST_EXACT; y_result <= ry;
            done <= 1'b1; state <= S_IDLE;
          end else if (first && q < $signed(rx)) begin
            status <= stli_pkg::ST_CLAMPED; y_result <= ry;
            done <= 1'b1; state <= S_IDLE;
          end else if (!first && q < $signed(rx) && $signed(px) < q) begin
            bx <= rx; by <= ry; state <= S_DIV;
          end else if (j + 1'b1 == count) begin
            status <= stli_pkg::ST_CLAMPED; y_result <= ry;
            done <= 1'b1; state <= S_IDLE;
          end else begin
            px <= rx; py <= ry; first <= 1'b0;
            j <= j + 1'b1; state <= S_QR;
          end
        end
        // register the product, then start the divider on magnitudes
        S_DIV: begin
          prod <= 34'(dq) * 34'(dy);
          state <= S_DWAIT;
          first <= 1'b1;
        end
        S_DWAIT: begin
          if (first) begin
            first <= 1'b0;
            neg <= prod[33];
            dreq.start   <= 1'b1;
            dreq.num_mag <= prod[33] ? NW'(-prod) : NW'(prod);
            dreq.den     <= 17'(bx) - 17'(px);
          end else if (ddone) begin
            status <= stli_pkg::ST_INTERP;
            y_result <= py + (neg ? -16'(quot) : 16'(quot));
            done <= 1'b1; state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

/* rtl/stli_ram.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stli_ram: generic single-port RAM
// One write and one read per cycle, registered read data (old word on a write).
// ----------------------------------------------------------------------------
module stli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write one word and read the old word at the same address
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* rtl/stli_div.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// stli_div: unsigned restoring divider
// One quotient bit per cycle over the numerator magnitude.
// ----------------------------------------------------------------------------
module stli_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire stli_pkg::div_req_t req,
  output logic                    done,
  output logic [stli_pkg::NUM_W-1:0] quot
);

  localparam int NW = stli_pkg::NUM_W;
  localparam int DW = stli_pkg::DEN_W;

  logic [NW-1:0]       num;
  logic [DW-1:0]       den;
  logic [DW:0]         rem;
  logic [$clog2(NW):0] cnt;
  logic                run;
  logic [DW:0]         trial;

  assign trial = {rem[DW-1:0], num[NW-1]};

  // shift in one numerator bit, subtract when it fits
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run  <= 1'b1;
        num  <= req.num_mag;
        den  <= req.den;
        rem  <= '0;
        quot <= '0;
        cnt  <= '0;
      end else if (run) begin
        num <= {num[NW-2:0], 1'b0};
        if (trial >= {1'b0, den}) begin
          rem  <= trial - {1'b0, den};
          quot <= {quot[NW-2:0], 1'b1};
        end else begin
          rem  <= trial;
          quot <= {quot[NW-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == ($clog2(NW)+1)'(NW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire
